// ===== sv/hcs_pkg.sv =====
package hcs_pkg;

  // Width of the step register and of the curve parameter t (Q0.16; t up to 1.0).
  localparam int T_STEP_BITS = 17;
  localparam int T_BITS      = 17;
  // t^2 and t^3 in Q0.32, up to 1.0.
  localparam int T2_BITS     = 33;
  // Basis values are signed Q.32 and may reach 1.0.
  localparam int BASIS_W     = 34;
  localparam int FRAC_BITS   = 32;

  localparam logic [T_STEP_BITS-1:0] T_STEP_RESET = 17'd662;
  localparam logic [T_BITS-1:0]      T_ONE        = 17'd65536;
  localparam logic signed [BASIS_W-1:0] BASIS_ONE = 34'sh1_0000_0000;

  typedef logic signed [BASIS_W-1:0] hcs_basis_val_t;

  // The four Hermite basis values for one item.
  typedef struct packed {
    hcs_basis_val_t h00;
    hcs_basis_val_t h10;
    hcs_basis_val_t h01;
    hcs_basis_val_t h11;
  } hcs_basis_t;

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic valid;
    logic clip;
  } hcs_ctl_t;

endpackage

// ===== sv/hcs_param.sv =====
module hcs_param #(
  parameter int INDEX_BITS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [INDEX_BITS-1:0]         in_index,
  input  logic [hcs_pkg::T_STEP_BITS-1:0] t_step,
  output hcs_pkg::hcs_ctl_t             basis_ctl,
  output hcs_pkg::hcs_basis_t           basis
);
  import hcs_pkg::*;

  localparam int TPROD_W = T_STEP_BITS + INDEX_BITS;
  localparam int T3P_W   = T2_BITS + T_BITS;
  localparam logic [T3P_W-1:0] ROUND16 = T3P_W'(32768);

  hcs_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  hcs_ctl_t ctl1_nxt;

  logic [TPROD_W-1:0] t_prod;
  logic               t_over;
  logic [T_BITS-1:0]  t1_nxt, t1_r, t1b_r, t1c_r;
  logic [T2_BITS-1:0] t2_nxt, t2_r, t2b_r;
  logic [T3P_W-1:0]   t3_prod;
  logic [T2_BITS-1:0] t3_nxt, t3_r;
  hcs_basis_val_t     s1, s2, s3;
  hcs_basis_t         basis_nxt, basis_r;

  // Stage 1: t = index * step, held at 1.0.
  always_comb begin
    t_prod = TPROD_W'(t_step) * TPROD_W'(in_index);
    t_over = t_prod > TPROD_W'(T_ONE);
    t1_nxt = t_over ? T_ONE : t_prod[T_BITS-1:0];
    ctl1_nxt.valid = in_valid;
    ctl1_nxt.clip  = t_over;
  end

  // Stage 2: exact square of t.
  assign t2_nxt = T2_BITS'(t1_r) * T2_BITS'(t1_r);

  // Stage 3: cube of t, rounded half up back to Q0.32.
  always_comb begin
    t3_prod = T3P_W'(t2_r) * T3P_W'(t1b_r);
    t3_nxt  = T2_BITS'((t3_prod + ROUND16) >> 16);
  end

  // Stage 4: basis values; intermediate wrap is harmless since results fit.
  always_comb begin
    s3 = $signed(BASIS_W'(t3_r));
    s2 = $signed(BASIS_W'(t2b_r));
    s1 = $signed(BASIS_W'({t1c_r, 16'b0}));
    basis_nxt.h00 = (s3 <<< 1) - (s2 <<< 1) - s2 + BASIS_ONE;
    basis_nxt.h10 = s3 - (s2 <<< 1) + s1;
    basis_nxt.h01 = (s2 <<< 1) + s2 - (s3 <<< 1);
    basis_nxt.h11 = s3 - s2;
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Data registers of the four stages.
  always_ff @(posedge clk) begin
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    t1b_r   <= t1_r;
    t3_r    <= t3_nxt;
    t2b_r   <= t2_r;
    t1c_r   <= t1b_r;
    basis_r <= basis_nxt;
  end

  assign basis_ctl = ctl4_r;
  assign basis     = basis_r;

  // A clipped parameter is held at exactly 1.0.
  a_clip_at_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctl1_r.valid && ctl1_r.clip |-> t1_r == T_ONE)
    else $error("clipped t is not 1.0");

  // The end-point weights always sum to one.
  a_partition: assert property (@(posedge clk) disable iff (!rst_n)
    ctl4_r.valid |-> basis_r.h00 + basis_r.h01 == BASIS_ONE)
    else $error("h00 + h01 is not 1.0");

endmodule

// ===== sv/hcs_blend.sv =====
module hcs_blend #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] p0,
  input  logic signed [COORD_BITS-1:0] m0,
  input  logic signed [COORD_BITS-1:0] p1,
  input  logic signed [COORD_BITS-1:0] m1,
  input  hcs_pkg::hcs_basis_t          basis,
  output logic signed [COORD_BITS-1:0] coord,
  output logic                         sat
);
  import hcs_pkg::*;

  localparam int PROD_W = COORD_BITS + BASIS_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF_LSB =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = Q_MAX[COORD_BITS-1:0];
  localparam logic signed [COORD_BITS-1:0] C_MIN = Q_MIN[COORD_BITS-1:0];

  logic signed [PROD_W-1:0]     prod_nxt [4];
  logic signed [PROD_W-1:0]     prod_r   [4];
  logic signed [ACC_W-1:0]      acc_nxt, acc_r, acc_rnd;
  logic signed [Q_W-1:0]        q;
  logic signed [COORD_BITS-1:0] coord_nxt, coord_r;
  logic                         sat_nxt, sat_r;

  // Four products of a point or tangent with its weight.
  always_comb begin
    prod_nxt[0] = PROD_W'(p0) * PROD_W'(basis.h00);
    prod_nxt[1] = PROD_W'(m0) * PROD_W'(basis.h10);
    prod_nxt[2] = PROD_W'(p1) * PROD_W'(basis.h01);
    prod_nxt[3] = PROD_W'(m1) * PROD_W'(basis.h11);
  end

  // Sum of the four products.
  assign acc_nxt = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1])
                 + ACC_W'(prod_r[2]) + ACC_W'(prod_r[3]);

  // Round half toward plus infinity to Q2.14, then saturate.
  always_comb begin
    acc_rnd = acc_r + HALF_LSB;
    q       = acc_rnd[ACC_W-1:FRAC_BITS];
    if (q > Q_MAX) begin
      coord_nxt = C_MAX;
      sat_nxt   = 1'b1;
    end else if (q < Q_MIN) begin
      coord_nxt = C_MIN;
      sat_nxt   = 1'b1;
    end else begin
      coord_nxt = q[COORD_BITS-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    acc_r   <= acc_nxt;
    coord_r <= coord_nxt;
    sat_r   <= sat_nxt;
  end

  assign coord = coord_r;
  assign sat   = sat_r;

  // A saturated coordinate sits on one of the range bounds.
  a_sat_bound: assert property (@(posedge clk)
    sat_r |-> coord_r == C_MAX || coord_r == C_MIN)
    else $error("saturated coordinate is not at a bound");

endmodule

// ===== sv/hermite_curve_sampler.sv =====
// Cubic Hermite curve sampler.
// An item (start point, start tangent, end point, end tangent in Q2.14 and a
// sample index) is taken at a clock edge where start is high and busy is low.
// The block forms t = sample_index * t_step, held at 1.0, builds the four
// Hermite weights and returns the curve point x and y, rounded and saturated.
// Each result appears on the out_ ports for one cycle with out_valid high;
// out_clipped reports a held t or a saturated coordinate.
// One item can be taken every cycle; the pipeline has seven register stages,
// the deepest being the t^3 multiply and the 16 x 34 bit weight multiplies.
// The receiver cannot stall, so nothing holds the pipeline and busy stays
// low after reset.
// The step register is written through cfg_valid / cfg_ready / cfg_t_step;
// the user must do so only while no item is in flight; this is not enforced.
// Reset clears all valid bits, loads the step with its default of one
// ninety-ninth, and holds busy high; busy clears once reset is released.
module hermite_curve_sampler #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    in_start_x,
  input  logic signed [COORD_BITS-1:0]    in_start_y,
  input  logic signed [COORD_BITS-1:0]    in_start_tangent_x,
  input  logic signed [COORD_BITS-1:0]    in_start_tangent_y,
  input  logic signed [COORD_BITS-1:0]    in_end_x,
  input  logic signed [COORD_BITS-1:0]    in_end_y,
  input  logic signed [COORD_BITS-1:0]    in_end_tangent_x,
  input  logic signed [COORD_BITS-1:0]    in_end_tangent_y,
  input  logic [INDEX_BITS-1:0]           in_sample_index,
  output logic                            out_valid,
  output logic signed [COORD_BITS-1:0]    out_curve_x,
  output logic signed [COORD_BITS-1:0]    out_curve_y,
  output logic                            out_clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hcs_pkg::T_STEP_BITS-1:0] cfg_t_step
);
  import hcs_pkg::*;

  // Depth of the weight pipeline and of the blend pipeline.
  localparam int PT_STAGES    = 4;
  localparam int BLEND_STAGES = 3;

  // Slots of the coordinate delay line.
  localparam int IX_SX  = 0;
  localparam int IX_SY  = 1;
  localparam int IX_STX = 2;
  localparam int IX_STY = 3;
  localparam int IX_EX  = 4;
  localparam int IX_EY  = 5;
  localparam int IX_ETX = 6;
  localparam int IX_ETY = 7;
  localparam int N_PTS  = 8;

  logic                         busy_r;
  logic                         accept;
  logic [T_STEP_BITS-1:0]       t_step_r;
  logic signed [COORD_BITS-1:0] pts_r [PT_STAGES][N_PTS];
  hcs_ctl_t                     basis_ctl;
  hcs_basis_t                   basis;
  hcs_ctl_t                     ctl_d_r [BLEND_STAGES];
  logic signed [COORD_BITS-1:0] x_coord, y_coord;
  logic                         x_sat, y_sat;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // Busy only while coming out of reset; the step register resets to default.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      t_step_r <= T_STEP_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        t_step_r <= cfg_t_step;
      end
    end
  end

  // Coordinates wait alongside the weight pipeline.
  always_ff @(posedge clk) begin
    pts_r[0][IX_SX]  <= in_start_x;
    pts_r[0][IX_SY]  <= in_start_y;
    pts_r[0][IX_STX] <= in_start_tangent_x;
    pts_r[0][IX_STY] <= in_start_tangent_y;
    pts_r[0][IX_EX]  <= in_end_x;
    pts_r[0][IX_EY]  <= in_end_y;
    pts_r[0][IX_ETX] <= in_end_tangent_x;
    pts_r[0][IX_ETY] <= in_end_tangent_y;
    for (int s = 1; s < PT_STAGES; s++) begin
      pts_r[s] <= pts_r[s-1];
    end
  end

  hcs_param #(
    .INDEX_BITS (INDEX_BITS)
  ) u_param (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_index  (in_sample_index),
    .t_step    (t_step_r),
    .basis_ctl (basis_ctl),
    .basis     (basis)
  );

  hcs_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend_x (
    .clk   (clk),
    .p0    (pts_r[PT_STAGES-1][IX_SX]),
    .m0    (pts_r[PT_STAGES-1][IX_STX]),
    .p1    (pts_r[PT_STAGES-1][IX_EX]),
    .m1    (pts_r[PT_STAGES-1][IX_ETX]),
    .basis (basis),
    .coord (x_coord),
    .sat   (x_sat)
  );

  hcs_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend_y (
    .clk   (clk),
    .p0    (pts_r[PT_STAGES-1][IX_SY]),
    .m0    (pts_r[PT_STAGES-1][IX_STY]),
    .p1    (pts_r[PT_STAGES-1][IX_EY]),
    .m1    (pts_r[PT_STAGES-1][IX_ETY]),
    .basis (basis),
    .coord (y_coord),
    .sat   (y_sat)
  );

  // Valid and t clip follow the blend stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < BLEND_STAGES; s++) begin
        ctl_d_r[s].valid <= 1'b0;
      end
    end else begin
      ctl_d_r[0] <= basis_ctl;
      for (int s = 1; s < BLEND_STAGES; s++) begin
        ctl_d_r[s] <= ctl_d_r[s-1];
      end
    end
  end

  assign out_valid   = ctl_d_r[BLEND_STAGES-1].valid;
  assign out_curve_x = x_coord;
  assign out_curve_y = y_coord;
  assign out_clipped = ctl_d_r[BLEND_STAGES-1].clip | x_sat | y_sat;

  // Every accepted item comes out as a result.
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("accepted item did not produce a result");

  // No result without a matching accepted item.
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 7))
    else $error("result without a matching item");

endmodule

// ===== verif/tb_hermite_curve_sampler.sv =====
`timescale 1ns / 100ps

module tb_hermite_curve_sampler;
  import hcs_pkg::*;

  localparam int COORD_W      = 16;
  localparam int INDEX_W      = 7;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic {ENTRY_ITEM, ENTRY_STEP} entry_kind_t;

  // One segment sample as it goes into the block.
  typedef struct {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_tangent_x;
    logic signed [COORD_W-1:0] start_tangent_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_tangent_x;
    logic signed [COORD_W-1:0] end_tangent_y;
    logic [INDEX_W-1:0]        sample_index;
  } segment_sample_t;

  // One curve point as it comes out of the block.
  typedef struct {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      clipped;
  } curve_point_t;

  // The feed holds items and step writes in the order they are applied.
  typedef struct {
    entry_kind_t           kind;
    segment_sample_t       seg;
    logic [T_STEP_BITS-1:0] step;
  } feed_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_start_x = '0;
  logic signed [COORD_W-1:0] in_start_y = '0;
  logic signed [COORD_W-1:0] in_start_tangent_x = '0;
  logic signed [COORD_W-1:0] in_start_tangent_y = '0;
  logic signed [COORD_W-1:0] in_end_x = '0;
  logic signed [COORD_W-1:0] in_end_y = '0;
  logic signed [COORD_W-1:0] in_end_tangent_x = '0;
  logic signed [COORD_W-1:0] in_end_tangent_y = '0;
  logic [INDEX_W-1:0] in_sample_index = '0;
  logic out_valid;
  logic signed [COORD_W-1:0] out_curve_x;
  logic signed [COORD_W-1:0] out_curve_y;
  logic out_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [T_STEP_BITS-1:0] cfg_t_step = '0;

  feed_entry_t     feed_q[$];
  curve_point_t    expected_points[$];
  segment_sample_t driven_seg;
  logic [T_STEP_BITS-1:0] step_shadow = T_STEP_RESET;
  int mismatches = 0;
  int cycle_count = 0;
  int wait_cycles = 0;
  int burst_left = 0;

  hermite_curve_sampler #(
    .COORD_BITS(COORD_W),
    .INDEX_BITS(INDEX_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_start_tangent_x(in_start_tangent_x),
    .in_start_tangent_y(in_start_tangent_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_end_tangent_x  (in_end_tangent_x),
    .in_end_tangent_y  (in_end_tangent_y),
    .in_sample_index   (in_sample_index),
    .out_valid         (out_valid),
    .out_curve_x       (out_curve_x),
    .out_curve_y       (out_curve_y),
    .out_clipped       (out_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_t_step        (cfg_t_step)
  );

  always #5 clk = ~clk;

  // Weighted sum of the four control values, rounded half up to Q2.14 and saturated.
  function automatic logic signed [COORD_W-1:0] blend_coord(
    input longint p0, m0, p1, m1,
    input longint h00, h10, h01, h11,
    inout bit clip);
    longint acc;
    longint q;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -(longint'(1) <<< (COORD_W - 1));
    acc = p0 * h00 + m0 * h10 + p1 * h01 + m1 * h11;
    q = (acc + (longint'(1) <<< 31)) >>> 32;
    if (q > hi) begin
      q = hi;
      clip = 1'b1;
    end else if (q < lo) begin
      q = lo;
      clip = 1'b1;
    end
    return q[COORD_W-1:0];
  endfunction

  // Curve point for one sample under the given step.
  function automatic curve_point_t hermite_point(input segment_sample_t seg,
                                                 input logic [T_STEP_BITS-1:0] step);
    curve_point_t pt;
    bit clip;
    longint t;
    longint t2;
    longint t3;
    longint t1;
    longint h00;
    longint h10;
    longint h01;
    longint h11;
    clip = 1'b0;
    t = longint'(seg.sample_index) * longint'(step);
    if (t > longint'(T_ONE)) begin
      t = longint'(T_ONE);
      clip = 1'b1;
    end
    // t^2 is exact in Q0.32; t^3 is rounded back from Q0.48.
    t2 = t * t;
    t3 = (t2 * t + (longint'(1) <<< 15)) >>> 16;
    t1 = t <<< 16;
    h00 = 2 * t3 - 3 * t2 + (longint'(1) <<< FRAC_BITS);
    h10 = t3 - 2 * t2 + t1;
    h01 = -2 * t3 + 3 * t2;
    h11 = t3 - t2;
    pt.curve_x = blend_coord(longint'(seg.start_x), longint'(seg.start_tangent_x),
                             longint'(seg.end_x), longint'(seg.end_tangent_x),
                             h00, h10, h01, h11, clip);
    pt.curve_y = blend_coord(longint'(seg.start_y), longint'(seg.start_tangent_y),
                             longint'(seg.end_y), longint'(seg.end_tangent_y),
                             h00, h10, h01, h11, clip);
    pt.clipped = clip;
    return pt;
  endfunction

  function automatic segment_sample_t make_seg(input int px, py, tx, ty,
                                               input int ex, ey, etx, ety,
                                               input int idx);
    segment_sample_t seg;
    seg.start_x = px[COORD_W-1:0];
    seg.start_y = py[COORD_W-1:0];
    seg.start_tangent_x = tx[COORD_W-1:0];
    seg.start_tangent_y = ty[COORD_W-1:0];
    seg.end_x = ex[COORD_W-1:0];
    seg.end_y = ey[COORD_W-1:0];
    seg.end_tangent_x = etx[COORD_W-1:0];
    seg.end_tangent_y = ety[COORD_W-1:0];
    seg.sample_index = idx[INDEX_W-1:0];
    return seg;
  endfunction

  // Random coordinate: full range now and then, otherwise a moderate magnitude.
  function automatic int rand_coord(input bit full, input int span);
    if (full)
      return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic segment_sample_t rand_seg();
    bit full;
    full = ($urandom_range(0, 3) == 0);
    return make_seg(rand_coord(full, 12000), rand_coord(full, 12000),
                    rand_coord(full, 20000), rand_coord(full, 20000),
                    rand_coord(full, 12000), rand_coord(full, 12000),
                    rand_coord(full, 20000), rand_coord(full, 20000),
                    int'($urandom_range(0, 127)));
  endfunction

  task automatic add_item(input segment_sample_t seg);
    feed_entry_t e;
    e.kind = ENTRY_ITEM;
    e.seg = seg;
    e.step = '0;
    feed_q = {feed_q, e};
  endtask

  task automatic add_step_write(input logic [T_STEP_BITS-1:0] step);
    feed_entry_t e;
    e.kind = ENTRY_STEP;
    e.seg = make_seg(0, 0, 0, 0, 0, 0, 0, 0, 0);
    e.step = step;
    feed_q = {feed_q, e};
  endtask

  // Mostly sweeps of one segment along its index, as a tessellator issues
  // them, mixed with lone random samples.
  task automatic add_random(input int count);
    segment_sample_t seg;
    int added;
    int idx;
    int stride;
    int run;
    added = 0;
    while (added < count) begin
      seg = rand_seg();
      if ($urandom_range(0, 9) < 6) begin
        idx = $urandom_range(0, 40);
        stride = $urandom_range(1, 8);
        run = $urandom_range(6, 20);
        while (run > 0 && idx <= 127 && added < count) begin
          seg.sample_index = idx[INDEX_W-1:0];
          add_item(seg);
          idx += stride;
          run--;
          added++;
        end
      end else begin
        add_item(seg);
        added++;
      end
    end
  endtask

  // Driver: one item or one step write at a time, with random gaps.
  always @(posedge clk) begin
    feed_entry_t e;
    logic start_n;
    logic cfg_valid_n;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      start_n = start;
      cfg_valid_n = cfg_valid;
      if (start && !busy) begin
        expected_points = {expected_points, hermite_point(driven_seg, step_shadow)};
        start_n = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        step_shadow = cfg_t_step;
        cfg_valid_n = 1'b0;
      end
      if (!start_n && !cfg_valid_n) begin
        if (wait_cycles > 0) begin
          wait_cycles--;
        end else if (feed_q.size() > 0) begin
          if (feed_q[0].kind == ENTRY_ITEM) begin
            e = feed_q.pop_front();
            driven_seg = e.seg;
            in_start_x <= e.seg.start_x;
            in_start_y <= e.seg.start_y;
            in_start_tangent_x <= e.seg.start_tangent_x;
            in_start_tangent_y <= e.seg.start_tangent_y;
            in_end_x <= e.seg.end_x;
            in_end_y <= e.seg.end_y;
            in_end_tangent_x <= e.seg.end_tangent_x;
            in_end_tangent_y <= e.seg.end_tangent_y;
            in_sample_index <= e.seg.sample_index;
            start_n = 1'b1;
            // Gap before the next item; bursts run with no gap at all.
            if (burst_left > 0) begin
              burst_left--;
              wait_cycles = 0;
            end else begin
              wait_cycles = $urandom_range(0, 17);
              if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(5, 40);
            end
          end else if (expected_points.size() == 0) begin
            // The step changes only once every item has come back.
            e = feed_q.pop_front();
            cfg_t_step <= e.step;
            cfg_valid_n = 1'b1;
          end
        end
      end
      start <= start_n;
      cfg_valid <= cfg_valid_n;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with nothing expected: x %0d y %0d clipped %0b",
                 $time, out_curve_x, out_curve_y, out_clipped);
        mismatches++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_curve_x !== exp_pt.curve_x) begin
          $display("%0t: curve_x expected %0d, actual %0d",
                   $time, exp_pt.curve_x, out_curve_x);
          mismatches++;
        end
        if (out_curve_y !== exp_pt.curve_y) begin
          $display("%0t: curve_y expected %0d, actual %0d",
                   $time, exp_pt.curve_y, out_curve_y);
          mismatches++;
        end
        if (out_clipped !== exp_pt.clipped) begin
          $display("%0t: clipped expected %0b, actual %0b",
                   $time, exp_pt.clipped, out_clipped);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [T_STEP_BITS-1:0] steps[8];
    segment_sample_t seg;

    // Directed items under the default step of about one ninety-ninth.
    add_item(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    add_item(make_seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
    // Coordinate overflow in both directions.
    add_item(make_seg(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, 30));
    add_item(make_seg(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 30));
    // Only x overflows.
    add_item(make_seg(32767, 0, 32767, 100, 32767, 0, -32768, -100, 25));
    // Last index below one, then the parameter held at one.
    add_item(make_seg(1000, -2000, 30000, -30000, -5000, 7000, 16384, -16384, 98));
    add_item(make_seg(1000, -2000, 30000, -30000, -5000, 7000, 16384, -16384, 99));
    add_item(make_seg(-1, 1, -1, 1, 32767, -32768, 0, 0, 127));
    add_item(make_seg('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h55));
    add_item(make_seg('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'h2A));
    add_item(make_seg(16384, -16384, 8192, 8192, -16384, 16384, -8192, -8192, 50));
    add_random(80);

    // Step settings: extremes, steps beyond one, and ordinary ones.
    steps = '{17'd0, 17'd1, 17'd516, 17'd65536, 17'd65537, 17'h1FFFF,
              17'd0, T_STEP_RESET};
    steps[6] = T_STEP_BITS'($urandom_range(2, 3000));
    foreach (steps[i]) begin
      add_step_write(steps[i]);
      // For steps of one and above, index 1 gives t of one or more, index 2 more still.
      seg = rand_seg();
      seg.sample_index = INDEX_W'(1);
      add_item(seg);
      seg.sample_index = INDEX_W'(2);
      add_item(seg);
      seg.sample_index = INDEX_W'(127);
      add_item(seg);
      add_random(80);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do
      @(negedge clk);
    while (feed_q.size() != 0 || start || cfg_valid || expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_points.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_points.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
sv/hcs_pkg.sv
sv/hcs_param.sv
sv/hcs_blend.sv
sv/hermite_curve_sampler.sv
verif/tb_hermite_curve_sampler.sv
